// ===== rtl/fifo_queue_with_prefix_reverse_macros.svh =====
// Assertion macros used by the checker file.
`ifndef FIFO_QUEUE_WITH_PREFIX_REVERSE_MACROS_SVH
`define FIFO_QUEUE_WITH_PREFIX_REVERSE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define FQR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fqr check failed");

// Next-cycle implication, disabled while reset is low.
`define FQR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fqr check failed");

`endif

// ===== rtl/fqr_pkg.sv =====
package fqr_pkg;

  localparam int DEPTH  = 16;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;

  localparam logic [1:0] OP_ENQ = 2'd0;
  localparam logic [1:0] OP_DEQ = 2'd1;
  localparam logic [1:0] OP_REV = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_BADK  = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DQ_WAIT,
    S_RV_RDA,
    S_RV_RDB,
    S_RV_WRA,
    S_RV_WRB,
    S_FIN
  } state_t;

endpackage

// ===== rtl/fqr_ram.sv =====
module fqr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/fifo_queue_with_prefix_reverse.sv =====
// Sequencing: enqueue and rejected operations go from accept through S_FIN to the result register,
//   dequeue adds S_DQ_WAIT, and a reverse of k entries makes one read-read-write-write pass per swapped
//   pair, floor(k/2) pairs, through the single-read, single-write slot RAM.
// A new beat is taken only once the last one has left S_FIN; it may be taken while the last result waits.
// Reset (rst_n low, synchronous): queue empty, head index zero, no result pending.
//   Slot RAM is not cleared; an unwritten slot may be read as a queue drains, but that word is masked.
module fifo_queue_with_prefix_reverse (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_func,
  input  logic signed [31:0]           in_push_value,
  input  logic [4:0]                   in_reverse_count,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [31:0]           out_popped_value,
  output logic signed [31:0]           out_head_value,
  output logic signed [31:0]           out_tail_value,
  output logic [4:0]                   out_occupancy,
  output logic                         out_is_empty,
  output logic [1:0]                   out_status
);

  localparam int AW = fqr_pkg::ADDR_W;
  localparam int CW = fqr_pkg::CNT_W;
  localparam int DW = fqr_pkg::DATA_W;

  // Ring position: base plus offset, wrapped once (both are below DEPTH).
  function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] base,
                                             input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (AW+1)'(fqr_pkg::DEPTH)) begin
      sum = sum - (AW+1)'(fqr_pkg::DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  fqr_pkg::state_t state_r, state_nxt;

  // Queue bookkeeping. head_r and tail_r shadow the oldest and newest slots.
  logic [AW-1:0] head_idx_r, head_idx_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [DW-1:0] head_r, head_nxt;
  logic [DW-1:0] tail_r, tail_nxt;
  logic [DW-1:0] popped_r, popped_nxt;
  logic [1:0]    status_r, status_nxt;

  // Reverse walk: lo and hi offsets from the head, tmp holds the low-side word.
  logic [AW-1:0] lo_r, lo_nxt;
  logic [AW-1:0] hi_r, hi_nxt;
  logic [DW-1:0] tmp_r, tmp_nxt;

  // Result register, parting the work from the result channel.
  logic          out_valid_r, out_valid_nxt;
  logic [DW-1:0] out_popped_r, out_popped_nxt;
  logic [DW-1:0] out_head_r, out_head_nxt;
  logic [DW-1:0] out_tail_r, out_tail_nxt;
  logic [CW-1:0] out_count_r, out_count_nxt;
  logic [1:0]    out_status_r, out_status_nxt;

  // Slot RAM port.
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [DW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [DW-1:0] ram_rdata;

  logic accept;
  logic is_full;
  logic is_none;
  logic rev_bad;
  logic rev_run;
  logic out_free;
  logic swap_more;
  logic [AW-1:0] lo_inc;
  logic [AW-1:0] hi_dec;

  fqr_ram #(
    .WIDTH(DW),
    .DEPTH(fqr_pkg::DEPTH)
  ) u_slots (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign in_ready = (state_r == fqr_pkg::S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  assign is_full = (count_r == CW'(fqr_pkg::DEPTH));
  assign is_none = (count_r == '0);
  // A reverse needs k strictly below the count; k of zero or one leaves the order alone.
  assign rev_bad = (32'(in_reverse_count) >= 32'(count_r));
  assign rev_run = !rev_bad && (in_reverse_count > 5'd1);

  // Advance the walk; another pair is left while the inner offsets have not met.
  assign lo_inc    = lo_r + AW'(1);
  assign hi_dec    = hi_r - AW'(1);
  assign swap_more = (lo_inc < hi_dec);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fqr_pkg::S_IDLE: begin
        if (accept) begin
          if (in_func == fqr_pkg::OP_DEQ && !is_none) begin
            state_nxt = fqr_pkg::S_DQ_WAIT;
          end else if (in_func == fqr_pkg::OP_REV && rev_run) begin
            state_nxt = fqr_pkg::S_RV_RDA;
          end else begin
            state_nxt = fqr_pkg::S_FIN;
          end
        end
      end
      fqr_pkg::S_DQ_WAIT: state_nxt = fqr_pkg::S_FIN;
      fqr_pkg::S_RV_RDA:  state_nxt = fqr_pkg::S_RV_RDB;
      fqr_pkg::S_RV_RDB:  state_nxt = fqr_pkg::S_RV_WRA;
      fqr_pkg::S_RV_WRA:  state_nxt = fqr_pkg::S_RV_WRB;
      fqr_pkg::S_RV_WRB: begin
        state_nxt = swap_more ? fqr_pkg::S_RV_RDA : fqr_pkg::S_FIN;
      end
      fqr_pkg::S_FIN: begin
        if (out_free) begin
          state_nxt = fqr_pkg::S_IDLE;
        end
      end
      default: state_nxt = fqr_pkg::S_IDLE;
    endcase
  end

  // Datapath, RAM control and result register.
  always_comb begin
    head_idx_nxt   = head_idx_r;
    count_nxt      = count_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    popped_nxt     = popped_r;
    status_nxt     = status_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    tmp_nxt        = tmp_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_popped_nxt = out_popped_r;
    out_head_nxt   = out_head_r;
    out_tail_nxt   = out_tail_r;
    out_count_nxt  = out_count_r;
    out_status_nxt = out_status_r;
    ram_we         = 1'b0;
    ram_waddr      = ring_pos(head_idx_r, lo_r);
    ram_wdata      = ram_rdata;
    ram_raddr      = ring_pos(head_idx_r, lo_r);

    unique case (state_r)
      fqr_pkg::S_IDLE: begin
        if (accept) begin
          popped_nxt = '0;
          status_nxt = fqr_pkg::ST_OK;
          unique case (in_func)
            fqr_pkg::OP_ENQ: begin
              if (is_full) begin
                status_nxt = fqr_pkg::ST_FULL;
              end else begin
                // Write at the rear; count is below DEPTH here so it fits the offset.
                ram_we    = 1'b1;
                ram_waddr = ring_pos(head_idx_r, count_r[AW-1:0]);
                ram_wdata = in_push_value;
                tail_nxt  = in_push_value;
                if (is_none) begin
                  head_nxt = in_push_value;
                end
                count_nxt = count_r + CW'(1);
              end
            end
            fqr_pkg::OP_DEQ: begin
              if (is_none) begin
                status_nxt = fqr_pkg::ST_EMPTY;
              end else begin
                // Pop the shadowed front, fetch the next oldest word.
                popped_nxt   = head_r;
                head_idx_nxt = ring_pos(head_idx_r, AW'(1));
                ram_raddr    = ring_pos(head_idx_r, AW'(1));
                count_nxt    = count_r - CW'(1);
              end
            end
            fqr_pkg::OP_REV: begin
              if (rev_bad) begin
                status_nxt = fqr_pkg::ST_BADK;
              end else if (rev_run) begin
                lo_nxt = '0;
                hi_nxt = AW'(in_reverse_count - 5'd1);
              end
            end
            default: begin
            end
          endcase
        end
      end
      fqr_pkg::S_DQ_WAIT: begin
        // New front arrives from the RAM; stale when the queue just drained, masked later.
        head_nxt = ram_rdata;
      end
      fqr_pkg::S_RV_RDA: begin
        ram_raddr = ring_pos(head_idx_r, lo_r);
      end
      fqr_pkg::S_RV_RDB: begin
        tmp_nxt   = ram_rdata;
        ram_raddr = ring_pos(head_idx_r, hi_r);
      end
      fqr_pkg::S_RV_WRA: begin
        // High-side word lands on the low side; the first pair refreshes the front.
        ram_we    = 1'b1;
        ram_waddr = ring_pos(head_idx_r, lo_r);
        ram_wdata = ram_rdata;
        if (lo_r == '0) begin
          head_nxt = ram_rdata;
        end
      end
      fqr_pkg::S_RV_WRB: begin
        // The rear is never inside the reversed prefix, so tail_r holds.
        ram_we    = 1'b1;
        ram_waddr = ring_pos(head_idx_r, hi_r);
        ram_wdata = tmp_r;
        lo_nxt    = lo_inc;
        hi_nxt    = hi_dec;
      end
      fqr_pkg::S_FIN: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_popped_nxt = popped_r;
          out_head_nxt   = is_none ? '0 : head_r;
          out_tail_nxt   = is_none ? '0 : tail_r;
          out_count_nxt  = count_r;
          out_status_nxt = status_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fqr_pkg::S_IDLE;
      head_idx_r  <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_idx_r  <= head_idx_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r       <= head_nxt;
    tail_r       <= tail_nxt;
    popped_r     <= popped_nxt;
    status_r     <= status_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    tmp_r        <= tmp_nxt;
    out_popped_r <= out_popped_nxt;
    out_head_r   <= out_head_nxt;
    out_tail_r   <= out_tail_nxt;
    out_count_r  <= out_count_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_popped_value = out_popped_r;
  assign out_head_value   = out_head_r;
  assign out_tail_value   = out_tail_r;
  assign out_occupancy    = 5'(out_count_r);
  assign out_is_empty     = (out_count_r == '0);
  assign out_status       = out_status_r;

endmodule

// ===== rtl/fqr_checker.sv =====
`include "fifo_queue_with_prefix_reverse_macros.svh"

module fqr_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_popped_value,
  input logic signed [31:0] out_head_value,
  input logic signed [31:0] out_tail_value,
  input logic [4:0]         out_occupancy,
  input logic               out_is_empty,
  input logic [1:0]         out_status
);

  `FQR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_head_value) && $stable(out_status) && $stable(out_occupancy))
  `FQR_ASSERT_NOW(a_empty_flag, clk, rst_n, out_valid, out_is_empty == (out_occupancy == 5'd0))
  `FQR_ASSERT_NOW(a_empty_zero, clk, rst_n, out_valid && out_is_empty, out_head_value == 32'sd0 && out_tail_value == 32'sd0)
  `FQR_ASSERT_NOW(a_underflow, clk, rst_n, out_valid && out_status == fqr_pkg::ST_EMPTY, out_is_empty && out_popped_value == 32'sd0)
  `FQR_ASSERT_NOW(a_bound, clk, rst_n, out_valid, 32'(out_occupancy) <= 32'(fqr_pkg::DEPTH))

endmodule

bind fifo_queue_with_prefix_reverse fqr_checker u_fqr_checker (.*);
